// File: hdl/wbv_pkg.sv
// ============================================================================
// wbv_pkg
// Shared types and constants of the write batch validator.
// ============================================================================
package wbv_pkg;

  // Header layout: an 8-byte sequence number, then a 4-byte record count.
  localparam logic [3:0] HEADER_BYTES = 4'd12;
  localparam logic [3:0] COUNT_OFFSET = 4'd8;
  // Index of the last length byte a varint32 may have.
  localparam logic [2:0] LEN_LAST_IDX = 3'd4;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SMALL    = 3'd1,
    ST_BADPUT   = 3'd2,
    ST_BADDEL   = 3'd3,
    ST_UNKNOWN  = 3'd4,
    ST_MISMATCH = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    PH_TAG   = 3'd0,
    PH_KLEN  = 3'd1,
    PH_KDATA = 3'd2,
    PH_VLEN  = 3'd3,
    PH_VDATA = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    TAG_NONE = 2'd0,
    TAG_PUT  = 2'd1,
    TAG_DEL  = 2'd2
  } tag_e;

  // Tag bytes from the configuration registers.
  typedef struct packed {
    logic [7:0] put_tag;
    logic [7:0] delete_tag;
  } cfg_t;

  // One classified byte as it travels through the queue.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    tag_e       tag;
  } tok_t;

endpackage

// File: hdl/wbv_front.sv
// ============================================================================
// wbv_front
// Input stage: registers each byte and classifies it against the tag bytes.
// ============================================================================
module wbv_front
  import wbv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_data_i,
  input  logic       in_last_i,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output tok_t       push_tok_o
);

  logic vld_q, vld_d;
  tok_t tok_q;
  tag_e tag_cls;

  // A put match wins when both tags are equal.
  always_comb begin
    if (in_data_i == cfg_i.put_tag) begin
      tag_cls = TAG_PUT;
    end else if (in_data_i == cfg_i.delete_tag) begin
      tag_cls = TAG_DEL;
    end else begin
      tag_cls = TAG_NONE;
    end
  end

  assign in_ready_o = !vld_q || push_ready_i;
  assign vld_d      = (in_valid_i && in_ready_o) || (vld_q && !push_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      tok_q.data <= in_data_i;
      tok_q.last <= in_last_i;
      tok_q.tag  <= tag_cls;
    end
  end

  assign push_valid_o = vld_q;
  assign push_tok_o   = tok_q;

endmodule

// File: hdl/wbv_queue.sv
// ============================================================================
// wbv_queue
// Small register queue that decouples the input stage from the parser.
// ============================================================================
module wbv_queue
  import wbv_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  tok_t push_tok_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output tok_t pop_tok_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  tok_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != CntFull);
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_tok_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_tok_i;
    end
  end

endmodule

// File: hdl/wbv_back.sv
// ============================================================================
// wbv_back
// Parser: walks header, records one byte per cycle unless stalled; holds result.
// ============================================================================
module wbv_back
  import wbv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pop_valid_i,
  output logic        pop_ready_o,
  input  tok_t        pop_tok_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output status_e     res_status_o,
  output logic [31:0] res_found_o,
  output logic [31:0] res_announced_o
);

  logic [3:0]  hidx_q, hidx_d;
  logic [31:0] expected_q, expected_d;
  logic [31:0] tally_q, tally_d;
  phase_e      phase_q, phase_d;
  logic        is_put_q, is_put_d;
  logic [31:0] accum_q, accum_d;
  logic [2:0]  lbi_q, lbi_d;
  logic [31:0] left_q, left_d;
  status_e     err_q, err_d;
  logic        out_vld_q, out_vld_d;
  status_e     out_status_q;
  logic [31:0] out_found_q, out_announced_q;

  logic        pop, pop_last;
  logic [7:0]  b;
  logic [4:0]  shamt;
  logic [31:0] accum_new;
  logic        field_done;
  phase_e      done_phase;
  phase_e      len_next;
  status_e     status_now;

  assign b        = pop_tok_i.data;
  // Only a closing beat needs the result register to be free.
  assign pop_ready_o = !out_vld_q || res_ready_i || !pop_tok_i.last;
  assign pop      = pop_valid_i && pop_ready_o;
  assign pop_last = pop && pop_tok_i.last;
  assign shamt    = {2'b00, lbi_q} * 5'd7;
  assign accum_new = accum_q | ({25'b0, b[6:0]} << shamt);

  always_comb begin
    hidx_d     = hidx_q;
    expected_d = expected_q;
    tally_d    = tally_q;
    phase_d    = phase_q;
    is_put_d   = is_put_q;
    accum_d    = accum_q;
    lbi_d      = lbi_q;
    left_d     = left_q;
    err_d      = err_q;
    field_done = 1'b0;
    done_phase = phase_q;
    len_next   = (phase_q == PH_KLEN) ? PH_KDATA : PH_VDATA;
    status_now = ST_OK;

    if (pop && (err_q == ST_OK)) begin
      if (hidx_q < HEADER_BYTES) begin
        if (hidx_q >= COUNT_OFFSET) begin
          expected_d = expected_q | ({24'b0, b} << {hidx_q[1:0], 3'b000});
        end
        hidx_d = hidx_q + 4'd1;
      end else begin
        unique case (phase_q)
          PH_TAG: begin
            case (pop_tok_i.tag)
              TAG_PUT: begin
                is_put_d = 1'b1;
                phase_d  = PH_KLEN;
              end
              TAG_DEL: begin
                is_put_d = 1'b0;
                phase_d  = PH_KLEN;
              end
              default: err_d = ST_UNKNOWN;
            endcase
          end
          PH_KLEN, PH_VLEN: begin
            if (b[7]) begin
              accum_d = accum_new;
              if (lbi_q >= LEN_LAST_IDX) begin
                err_d = is_put_q ? ST_BADPUT : ST_BADDEL;
              end else begin
                lbi_d = lbi_q + 3'd1;
              end
            end else begin
              left_d  = accum_new;
              accum_d = '0;
              lbi_d   = '0;
              phase_d = len_next;
              if (accum_new == '0) begin
                field_done = 1'b1;
                done_phase = len_next;
              end
            end
          end
          PH_KDATA, PH_VDATA: begin
            left_d = left_q - 32'd1;
            if (left_d == '0) begin
              field_done = 1'b1;
            end
          end
          default: phase_d = PH_TAG;
        endcase

        // A key of a put is followed by a value; anything else closes the record.
        if (field_done) begin
          if ((done_phase == PH_KDATA) && is_put_q) begin
            phase_d = PH_VLEN;
          end else begin
            tally_d = tally_q + 32'd1;
            phase_d = PH_TAG;
          end
        end
      end
    end

    if (err_d != ST_OK) begin
      status_now = err_d;
    end else if (hidx_d < HEADER_BYTES) begin
      status_now = ST_SMALL;
    end else if (phase_d != PH_TAG) begin
      status_now = is_put_d ? ST_BADPUT : ST_BADDEL;
    end else if (tally_d != expected_d) begin
      status_now = ST_MISMATCH;
    end else begin
      status_now = ST_OK;
    end
  end

  assign out_vld_d = (out_vld_q && !res_ready_i) || pop_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hidx_q     <= '0;
      expected_q <= '0;
      tally_q    <= '0;
      phase_q    <= PH_TAG;
      is_put_q   <= 1'b0;
      accum_q    <= '0;
      lbi_q      <= '0;
      left_q     <= '0;
      err_q      <= ST_OK;
      out_vld_q  <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (pop_last) begin
        hidx_q     <= '0;
        expected_q <= '0;
        tally_q    <= '0;
        phase_q    <= PH_TAG;
        is_put_q   <= 1'b0;
        accum_q    <= '0;
        lbi_q      <= '0;
        left_q     <= '0;
        err_q      <= ST_OK;
      end else begin
        hidx_q     <= hidx_d;
        expected_q <= expected_d;
        tally_q    <= tally_d;
        phase_q    <= phase_d;
        is_put_q   <= is_put_d;
        accum_q    <= accum_d;
        lbi_q      <= lbi_d;
        left_q     <= left_d;
        err_q      <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_last) begin
      out_status_q    <= status_now;
      out_found_q     <= tally_d;
      out_announced_q <= expected_d;
    end
  end

  assign res_valid_o     = out_vld_q;
  assign res_status_o    = out_status_q;
  assign res_found_o     = out_found_q;
  assign res_announced_o = out_announced_q;

endmodule

// File: hdl/write_batch_validator.sv
// ============================================================================
// write_batch_validator
// Checks a serialized write batch streamed one byte per beat and reports a
// status with the found and announced record counts on the closing beat.
// ============================================================================
// Throughput: one byte per cycle, bounded by the parser's per-byte state update,
// unless a closing byte waits on an untaken result. A closing byte passes the
// input register, the queue and the parser result register to the result beat.
// Reset (rst_ni, asynchronous, active low) empties the pipeline, clears all
// parse state, and sets put_tag to 1 and delete_tag to 0. No clearing pass.
// ============================================================================
module write_batch_validator
  import wbv_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte stream in.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // last_byte
  // Result out.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // [2:0] status, [34:3] records_found,
                                        // [66:35] announced_count, rest zero
  // Configuration port.
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  // Register map: put_tag at byte address 0, delete_tag at byte address 4.
  // The byte offset bits of the address are not decoded.
  localparam logic REG_PUT_TAG = 1'b0;
  localparam logic REG_DEL_TAG = 1'b1;

  cfg_t        cfg_q;
  logic        cfg_wr;

  logic        push_valid, push_ready;
  tok_t        push_tok;
  logic        pop_valid, pop_ready;
  tok_t        pop_tok;

  status_e     res_status;
  logic [31:0] res_found, res_announced;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes land on the access phase; the port never
  // inserts wait states. The user must write only while the stream is idle,
  // which the block does not enforce; the front end tags bytes with live values.
  // --------------------------------------------------------------------------
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.put_tag    <= 8'd1;
      cfg_q.delete_tag <= 8'd0;
    end else if (cfg_wr) begin
      unique case (paddr_i[2])
        REG_PUT_TAG: cfg_q.put_tag    <= pwdata_i[7:0];
        REG_DEL_TAG: cfg_q.delete_tag <= pwdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr_i[2])
      REG_PUT_TAG: prdata_o = {24'b0, cfg_q.put_tag};
      REG_DEL_TAG: prdata_o = {24'b0, cfg_q.delete_tag};
      default:     prdata_o = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Front end: registers each beat and tags it as put, delete or neither.
  // --------------------------------------------------------------------------
  wbv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_data_i    (s_axis_tdata_i),
    .in_last_i    (s_axis_tlast_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_tok_o   (push_tok)
  );

  // --------------------------------------------------------------------------
  // Queue: lets the front keep taking bytes while the result waits downstream.
  // --------------------------------------------------------------------------
  wbv_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_tok_i   (push_tok),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_tok_o    (pop_tok)
  );

  // --------------------------------------------------------------------------
  // Back end: header and record parser with the result register. It stalls
  // only on a closing byte while the previous result is still not taken.
  // --------------------------------------------------------------------------
  wbv_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_valid_i     (pop_valid),
    .pop_ready_o     (pop_ready),
    .pop_tok_i       (pop_tok),
    .res_valid_o     (m_axis_tvalid_o),
    .res_ready_i     (m_axis_tready_i),
    .res_status_o    (res_status),
    .res_found_o     (res_found),
    .res_announced_o (res_announced)
  );

  assign m_axis_tdata_o = {5'b0, res_announced, res_found, res_status};

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // A clean batch always has matching counts.
  a_ok_counts_match : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (res_status == ST_OK)) |-> (res_found == res_announced)
  ) else $error("ok status with differing record counts");

  // No record can be parsed before the header is complete.
  a_small_no_records : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (res_status == ST_SMALL)) |-> (res_found == '0)
  ) else $error("short batch reports parsed records");

  // A closing byte never overwrites a result that was not taken.
  a_no_result_overrun : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i && pop_valid && pop_tok.last) |-> !pop_ready
  ) else $error("closing byte popped while result is stalled");

endmodule
